// ----- rtl/sorted_priority_queue_core_defines.svh -----
// assertion macros for the sorted priority queue checker
// no dependencies; included by the checker file only
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// property checked outside reset
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property that must also hold while reset is applied
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int ELEM_W    = 32;
    localparam int PRIO_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    do_insert;
        logic    do_delete;
        logic    load_result;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic op_del;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/spq_datapath.sv -----
// datapath: captured beat, sorted shift-register cells, live count, result register
// depends on spq_pkg
`default_nettype none

module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spq_pkg::t_dp_cmd                  i_cmd,
    output spq_pkg::t_dp_stat                      o_stat,
    input  wire logic                              i_op,
    input  wire logic signed [spq_pkg::ELEM_W-1:0] i_element,
    input  wire logic        [spq_pkg::PRIO_W-1:0] i_priority_req,
    output logic        [spq_pkg::STATUS_W-1:0]    o_status,
    output logic signed [spq_pkg::ELEM_W-1:0]      o_out_element,
    output logic        [spq_pkg::PRIO_W-1:0]      o_out_priority,
    output logic        [spq_pkg::OCC_W-1:0]       o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                              r_op;
    logic signed [spq_pkg::ELEM_W-1:0] r_elem_in;
    logic        [spq_pkg::PRIO_W-1:0] r_prio_in;

    logic signed [spq_pkg::ELEM_W-1:0] r_elem [DEPTH];
    logic        [spq_pkg::PRIO_W-1:0] r_prio [DEPTH];
    logic        [CNT_W-1:0]           r_count;
    logic        [CNT_W-1:0]           n_count;
    logic        [DEPTH-1:0]           mv;

    spq_pkg::t_status                  r_res_status;
    logic signed [spq_pkg::ELEM_W-1:0] r_res_elem;
    logic        [spq_pkg::PRIO_W-1:0] r_res_prio;
    logic        [spq_pkg::OCC_W-1:0]  r_res_occ;
    logic        [CNT_W+spq_pkg::OCC_W-1:0] occ_wide;

    // captured input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_elem_in <= i_element;
            r_prio_in <= i_priority_req;
        end
    end

    // cells: parallel compare, shift up on insert, shift down on delete
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CNT_W-1:0] G_IDX = CNT_W'(g);
        logic signed [spq_pkg::ELEM_W-1:0] up_elem;
        logic        [spq_pkg::PRIO_W-1:0] up_prio;
        logic signed [spq_pkg::ELEM_W-1:0] dn_elem;
        logic        [spq_pkg::PRIO_W-1:0] dn_prio;

        assign mv[g] = (G_IDX < r_count) ? (r_prio[g] >= r_prio_in) : (G_IDX == r_count);

        if (g == 0) begin : g_head
            assign up_elem = r_elem_in;
            assign up_prio = r_prio_in;
        end else begin : g_body
            assign up_elem = mv[g-1] ? r_elem[g-1] : r_elem_in;
            assign up_prio = mv[g-1] ? r_prio[g-1] : r_prio_in;
        end

        if (g == DEPTH - 1) begin : g_tail
            assign dn_elem = r_elem[g];
            assign dn_prio = r_prio[g];
        end else begin : g_inner
            assign dn_elem = r_elem[g+1];
            assign dn_prio = r_prio[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.do_insert && mv[g]) begin
                r_elem[g] <= up_elem;
                r_prio[g] <= up_prio;
            end else if (i_cmd.do_delete) begin
                r_elem[g] <= dn_elem;
                r_prio[g] <= dn_prio;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.do_delete) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, n_count};

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_res_status <= i_cmd.code;
            r_res_elem   <= i_cmd.do_delete ? r_elem[0] : '0;
            r_res_prio   <= i_cmd.do_delete ? r_prio[0] : '0;
            r_res_occ    <= occ_wide[spq_pkg::OCC_W-1:0];
        end
    end

    assign o_stat.op_del = r_op;
    assign o_stat.full   = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty  = (r_count == '0);

    assign o_status       = r_res_status;
    assign o_out_element  = r_res_elem;
    assign o_out_priority = r_res_prio;
    assign o_occupancy    = r_res_occ;

endmodule

`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
// controller: beat capture, operation decode and result valid
// depends on spq_pkg
`default_nettype none

module spq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd       o_cmd
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.code  = spq_pkg::ST_INSERTED;
        o_in_stall  = 1'b1;
        case (r_state)
            spq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                if (out_free) begin
                    if (i_stat.op_del) begin
                        o_cmd.code = i_stat.empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_DELETED;
                    end else begin
                        o_cmd.code = i_stat.full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
                    end
                    o_cmd.do_insert   = (o_cmd.code == spq_pkg::ST_INSERTED);
                    o_cmd.do_delete   = (o_cmd.code == spq_pkg::ST_DELETED);
                    o_cmd.load_result = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue_core.sv -----
// Sorted priority queue of DEPTH entries held in shift-register cells, lowest priority value
// at the head. An insert compares its key against every live cell at once and opens a gap
// ahead of entries with an equal or greater key; a delete returns the head and shifts all
// cells down. Each beat is captured in the idle state; the controller then decodes the
// operation and the cells shift once the result register is free. No new beat is taken
// until then. The result register lets the next beat be taken while a result waits. Insert
// when full gives overflow, delete when empty gives underflow, and neither changes the
// queue. Depends on spq_pkg, spq_ctrl and spq_datapath.
`default_nettype none

module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic signed [spq_pkg::ELEM_W-1:0] i_element,
    input  wire logic        [spq_pkg::PRIO_W-1:0] i_priority_req,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic        [spq_pkg::STATUS_W-1:0]    o_out_status,
    output logic signed [spq_pkg::ELEM_W-1:0]      o_out_element,
    output logic        [spq_pkg::PRIO_W-1:0]      o_out_priority,
    output logic        [spq_pkg::OCC_W-1:0]       o_occupancy
);

    spq_pkg::t_dp_cmd  cmd;
    spq_pkg::t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_element      (i_element),
        .i_priority_req (i_priority_req),
        .o_status       (o_out_status),
        .o_out_element  (o_out_element),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

endmodule

`default_nettype wire

// ----- rtl/spq_checker.sv -----
// port-level checker for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_core_defines.svh
`default_nettype none
`include "sorted_priority_queue_core_defines.svh"

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic        [spq_pkg::STATUS_W-1:0] o_out_status,
    input wire logic signed [spq_pkg::ELEM_W-1:0]   o_out_element,
    input wire logic        [spq_pkg::PRIO_W-1:0]   o_out_priority,
    input wire logic        [spq_pkg::OCC_W-1:0]    o_occupancy
);

    `SPQ_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `SPQ_ASSERT(a_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "stalled beat dropped")
    `SPQ_ASSERT(a_overflow_full, i_clk, i_rst_n, o_out_valid && (o_out_status == spq_pkg::ST_OVERFLOW) |-> (o_occupancy == spq_pkg::OCC_W'(DEPTH)), "overflow while not full")
    `SPQ_ASSERT(a_underflow_empty, i_clk, i_rst_n, o_out_valid && (o_out_status == spq_pkg::ST_UNDERFLOW) |-> (o_occupancy == '0) && (o_out_element == '0) && (o_out_priority == '0), "underflow with data or entries")
    `SPQ_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "second beat taken before first executed")

endmodule

bind sorted_priority_queue_core spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_status   (o_out_status),
    .o_out_element  (o_out_element),
    .o_out_priority (o_out_priority),
    .o_occupancy    (o_occupancy)
);

`default_nettype wire

// ----- test/spq_checker.sv -----
// checker for sorted_priority_queue_core: watches both channels, keeps its own sorted queue
// and compares every result beat field by field with the oldest prediction
// depends on spq_pkg
module spq_tb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_op,
    input  logic signed [spq_pkg::ELEM_W-1:0] i_element,
    input  logic        [spq_pkg::PRIO_W-1:0] i_priority_req,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic        [spq_pkg::STATUS_W-1:0] i_out_status,
    input  logic signed [spq_pkg::ELEM_W-1:0] i_out_element,
    input  logic        [spq_pkg::PRIO_W-1:0] i_out_priority,
    input  logic        [spq_pkg::OCC_W-1:0]  i_occupancy,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_refusals
);
    import spq_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam int   DEPTH     = DEPTH_DEF;

    typedef struct packed {
        t_status                  status;
        logic signed [ELEM_W-1:0] elem;
        logic        [PRIO_W-1:0] prio;
        logic        [OCC_W-1:0]  occ;
    } t_queue_result;

    logic signed [ELEM_W-1:0] elem_cells [DEPTH];
    logic        [PRIO_W-1:0] key_cells  [DEPTH];
    int                       live_count;
    t_queue_result            expected_results [$];
    int                       fails;
    int                       checked;
    int                       refusals;

    assign o_fail_count = fails;
    assign o_pending    = expected_results.size();
    assign o_checked    = checked;
    assign o_refusals   = refusals;

    function automatic t_queue_result apply_queue_op(input logic op,
                                                     input logic signed [ELEM_W-1:0] el,
                                                     input logic [PRIO_W-1:0] pr);
        t_queue_result r;
        int            pos;
        r.status = ST_INSERTED;
        r.elem   = '0;
        r.prio   = '0;
        if (op == OP_INSERT) begin
            if (live_count >= DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                // open a gap ahead of every entry with an equal or larger key
                pos = live_count;
                while (pos > 0 && key_cells[pos-1] >= pr) begin
                    elem_cells[pos] = elem_cells[pos-1];
                    key_cells[pos]  = key_cells[pos-1];
                    pos--;
                end
                elem_cells[pos] = el;
                key_cells[pos]  = pr;
                live_count++;
            end
        end else if (live_count == 0) begin
            r.status = ST_UNDERFLOW;
        end else begin
            r.status = ST_DELETED;
            r.elem   = elem_cells[0];
            r.prio   = key_cells[0];
            for (pos = 1; pos < live_count; pos++) begin
                elem_cells[pos-1] = elem_cells[pos];
                key_cells[pos-1]  = key_cells[pos];
            end
            live_count--;
        end
        r.occ = OCC_W'(live_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            live_count = 0;
            expected_results.delete();
            fails    = 0;
            checked  = 0;
            refusals = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                want = apply_queue_op(i_op, i_element, i_priority_req);
                if (want.status == ST_OVERFLOW || want.status == ST_UNDERFLOW) refusals++;
                expected_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (i_out_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_out_status);
                        fails++;
                    end
                    if (i_out_element !== want.elem) begin
                        $error("out_element expected %0d got %0d", want.elem, i_out_element);
                        fails++;
                    end
                    if (i_out_priority !== want.prio) begin
                        $error("out_priority expected %0d got %0d", want.prio, i_out_priority);
                        fails++;
                    end
                    if (i_occupancy !== want.occ) begin
                        $error("occupancy expected %0d got %0d", want.occ, i_occupancy);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

// ----- test/tb_top.sv -----
// top of the sorted priority queue testbench: clock, reset, directed and random beats,
// random back-pressure and the verdict
// depends on spq_pkg, sorted_priority_queue_core and spq_tb_checker
module tb_top;
    import spq_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;
    localparam int   PHASE_BEATS = 517;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_op = OP_INSERT;
    logic signed [ELEM_W-1:0] in_element = '0;
    logic        [PRIO_W-1:0] in_priority = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic        [STATUS_W-1:0] out_status;
    logic signed [ELEM_W-1:0] out_element;
    logic        [PRIO_W-1:0] out_priority;
    logic        [OCC_W-1:0]  occupancy;

    int fail_count;
    int pending;
    int checked;
    int refusals;
    int tx_pct = 0;
    int rx_pct = 0;
    int beats_sent = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sorted_priority_queue_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (in_op),
        .i_element      (in_element),
        .i_priority_req (in_priority),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_status   (out_status),
        .o_out_element  (out_element),
        .o_out_priority (out_priority),
        .o_occupancy    (occupancy)
    );

    spq_tb_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_op           (in_op),
        .i_element      (in_element),
        .i_priority_req (in_priority),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_status   (out_status),
        .i_out_element  (out_element),
        .i_out_priority (out_priority),
        .i_occupancy    (occupancy),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_refusals     (refusals)
    );

    // receiver back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    task automatic send_beat(input logic op, input logic signed [ELEM_W-1:0] el,
                             input logic [PRIO_W-1:0] pr);
        while ($urandom_range(0, 99) < tx_pct) begin
            in_valid    <= 1'b0;
            in_op       <= 1'($urandom);
            in_element  <= $urandom;
            in_priority <= 16'($urandom);
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_op       <= op;
        in_element  <= el;
        in_priority <= pr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    function automatic logic [PRIO_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        // small keys give plenty of ties
        if (sel < 4) return PRIO_W'($urandom_range(0, 3));
        if (sel < 6) return ($urandom_range(0, 1) != 0) ? {PRIO_W{1'b1}} : '0;
        return PRIO_W'($urandom);
    endfunction

    task automatic run_random(input int count);
        int n;
        int left;
        int ins_pct;
        int mode;
        n = 0;
        while (n < count) begin
            // bursts that fill, drain or hover
            mode = $urandom_range(0, 2);
            ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            left = $urandom_range(4, 20);
            while (left > 0 && n < count) begin
                if ($urandom_range(0, 99) < ins_pct)
                    send_beat(OP_INSERT, $urandom, pick_key());
                else
                    send_beat(OP_DELETE, $urandom, 16'($urandom));
                left--;
                n++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_pct = 11;
        rx_pct = 82;
        // underflow on an empty queue
        send_beat(OP_DELETE, 32'sh1234_5678, 16'hA5A5);
        // extremes of element and key, ties placed ahead
        send_beat(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
        send_beat(OP_INSERT, 32'sh8000_0000, 16'h0000);
        send_beat(OP_INSERT, -32'sd1, 16'hFFFF);
        send_beat(OP_INSERT, 32'sd0, 16'h0000);
        send_beat(OP_INSERT, 32'sd5, 16'h8000);
        send_beat(OP_INSERT, 32'sd6, 16'h0001);
        send_beat(OP_INSERT, 32'sd7, 16'h7FFF);
        send_beat(OP_INSERT, 32'sd8, 16'hFFFE);
        // overflow once full
        send_beat(OP_INSERT, 32'sh5555_AAAA, 16'h0000);
        send_beat(OP_INSERT, -32'sd2, 16'hFFFF);
        repeat (8) send_beat(OP_DELETE, -32'sd1, 16'hFFFF);
        send_beat(OP_DELETE, 32'sd0, 16'h0000);
        send_beat(OP_INSERT, 32'sh2AAA_5555, 16'h1234);
        send_beat(OP_DELETE, 32'sd0, 16'h0000);
        send_beat(OP_DELETE, 32'sd0, 16'h0000);

        run_random(PHASE_BEATS);
        tx_pct = 82;
        rx_pct = 11;
        run_random(PHASE_BEATS);
        tx_pct = 0;
        rx_pct = 0;
        run_random(PHASE_BEATS);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("sent %0d beats in three back-pressure phases, %0d results checked",
                 beats_sent, checked);
        $display("%0d of them were overflow or underflow refusals", refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ----- sorted_priority_queue_core.f -----
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
test/spq_checker.sv
test/tb_top.sv
